// File: sv/ucs_pkg.sv
// ucs_pkg: shared types, codes and reset constants for the scanner session controller.
// No dependencies; imported by ucs_cfg_regs and udp_capture_session_fsm.
`timescale 1ns / 1ps

package ucs_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PortW   = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned HeadW   = 32;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CountW  = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 16;

  localparam logic [AddrW-1:0]  RstPeerAddr = 32'hC0A8_017B;
  localparam logic [PortW-1:0]  RstPeerPort = 16'd8020;
  localparam logic [TicksW-1:0] RstAckTimeout = '0;
  localparam logic [CountW-1:0] RstExpected  = '0;
  localparam logic [CountW-1:0] CountMax     = {CountW{1'b1}};

  // Ack datagram: 4-byte payload holding 2 (start) or 3 (stop)
  localparam logic [LenW-1:0]  AckLen       = 16'd4;
  localparam logic [HeadW-1:0] StartAckHead = 32'd2;
  localparam logic [HeadW-1:0] StopAckHead  = 32'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PEER_ADDR = 2'd0,
    CFG_PEER_PORT = 2'd1,
    CFG_ACK_TMO   = 2'd2,
    CFG_EXPECTED  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_DGRAM = 2'd2,
    MODE_TICK  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    NOTE_NORMAL     = 3'd0,
    NOTE_IDLE       = 3'd1,
    NOTE_START_ACK  = 3'd2,
    NOTE_UNEXP_START = 3'd3,
    NOTE_STOP_ACK   = 3'd4,
    NOTE_UNEXP_STOP = 3'd5
  } note_e;

  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    TMO_NONE  = 2'd0,
    TMO_START = 2'd1,
    TMO_STOP  = 2'd2
  } tmo_e;

  typedef struct packed {
    logic [AddrW-1:0]  peer_address;
    logic [PortW-1:0]  peer_port;
    logic [TicksW-1:0] ack_timeout;
    logic [CountW-1:0] expected_packets;
  } cfg_t;

  typedef struct packed {
    logic       deliver;
    note_e      note;
    req_e       send_request;
    tmo_e       timeout_event;
    logic       foreign_sender;
    logic       command_refused;
    logic [1:0] phase;
  } res_t;

endpackage

// File: sv/udp_capture_session_fsm.sv
// udp_capture_session_fsm: top level of the scanner session controller.
// Depends on ucs_pkg and ucs_cfg_regs.
`timescale 1ns / 1ps

// Session controller for a scanner data link. Every input beat (start
// command, stop command, received datagram or one-second tick, selected by
// s_axis_tuser) yields exactly one result beat. The block takes one beat per
// clock: the phase, packet counter and tick counter are updated in the cycle
// the beat is accepted, and the result is held in a single output register.
// s_axis_tready stays high whenever that register is empty or being drained,
// so throughput is one beat per cycle and the result is registered; only
// m_axis_tready low with a full output register stalls the input side.
// Datagrams not from the configured peer address and port are dropped and
// flagged. A 4-byte datagram holding 2 acks a start, holding 3 acks a stop.
// Configuration registers (index 0..3: peer address, peer port, ack timeout
// in ticks, expected packet count) are written through cfg_we_i and should
// only change while no beat is in flight.

module udp_capture_session_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Config write port
  input  logic                          cfg_we_i,
  input  logic [ucs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ucs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: source_address[31:0], source_port[47:32], payload_length[63:48],
  //        payload_head[95:64]
  input  logic [ucs_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]                    s_axis_tuser,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: deliver[0], note[3:1], send_request[5:4], timeout_event[7:6],
  //        foreign_sender[8], command_refused[9], phase[11:10], zero[15:12]
  output logic [ucs_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ucs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_START = 2'd1,
    PH_COLLECT    = 2'd2,
    PH_WAIT_STOP  = 2'd3
  } phase_e;

  cfg_t cfg;

  ucs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Session state
  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  // Output register
  logic                out_valid_q;
  res_t                res_q, res_d;

  // Unpack the input beat
  mode_e             mode;
  logic [AddrW-1:0]  src_addr;
  logic [PortW-1:0]  src_port;
  logic [LenW-1:0]   pay_len;
  logic [HeadW-1:0]  pay_head;

  assign mode     = mode_e'(s_axis_tuser);
  assign src_addr = s_axis_tdata[31:0];
  assign src_port = s_axis_tdata[47:32];
  assign pay_len  = s_axis_tdata[63:48];
  assign pay_head = s_axis_tdata[95:64];

  logic in_fire;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  logic              peer_ok, start_hit, stop_hit;
  logic [CountW-1:0] count_inc;

  assign peer_ok   = (src_addr == cfg.peer_address) && (src_port == cfg.peer_port);
  assign start_hit = (pay_len == AckLen) && (pay_head == StartAckHead);
  assign stop_hit  = (pay_len == AckLen) && (pay_head == StopAckHead);
  // saturating packet count
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    ticks_d = ticks_q;
    res_d   = '0;

    unique case (mode)
      MODE_START: begin
        if (phase_q != PH_IDLE) begin
          res_d.command_refused = 1'b1;
        end else begin
          res_d.send_request = REQ_START;
          count_d = '0;
          ticks_d = cfg.ack_timeout;
          phase_d = PH_WAIT_START;
        end
      end
      MODE_STOP: begin
        if (phase_q != PH_COLLECT) begin
          res_d.command_refused = 1'b1;
        end else begin
          res_d.send_request = REQ_STOP;
          ticks_d = cfg.ack_timeout;
          phase_d = PH_WAIT_STOP;
        end
      end
      MODE_DGRAM: begin
        if (!peer_ok) begin
          res_d.foreign_sender = 1'b1;
        end else begin
          res_d.deliver = 1'b1;
          unique case (phase_q)
            PH_IDLE: res_d.note = NOTE_IDLE;
            PH_WAIT_START: begin
              if (start_hit) begin
                res_d.note = NOTE_START_ACK;
                phase_d = PH_COLLECT;
              end else begin
                res_d.note = NOTE_UNEXP_START;
              end
            end
            PH_COLLECT: begin
              res_d.note = NOTE_NORMAL;
              count_d = count_inc;
              if (count_inc >= cfg.expected_packets) begin
                res_d.send_request = REQ_STOP;
                ticks_d = cfg.ack_timeout;
                phase_d = PH_WAIT_STOP;
              end
            end
            PH_WAIT_STOP: begin
              if (stop_hit) begin
                res_d.note = NOTE_STOP_ACK;
                phase_d = PH_IDLE;
              end else begin
                res_d.note = NOTE_UNEXP_STOP;
              end
            end
            default: ;
          endcase
        end
      end
      MODE_TICK: begin
        if (phase_q == PH_WAIT_START || phase_q == PH_WAIT_STOP) begin
          // a timeout of 0 or 1 fires on the first tick
          if (ticks_q <= TicksW'(1)) begin
            res_d.timeout_event = (phase_q == PH_WAIT_START) ? TMO_START : TMO_STOP;
            phase_d = PH_IDLE;
            ticks_d = '0;
          end else begin
            ticks_d = ticks_q - 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_d.phase = phase_d;
  end

  // State and result register; the result is loaded only with an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      count_q     <= '0;
      ticks_q     <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (in_fire) begin
        phase_q     <= phase_d;
        count_q     <= count_d;
        ticks_q     <= ticks_d;
        out_valid_q <= 1'b1;
        res_q       <= res_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q.phase, res_q.command_refused,
                          res_q.foreign_sender, res_q.timeout_event,
                          res_q.send_request, res_q.note, res_q.deliver};

  // Checks on the held result
  a_tmo_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.timeout_event != TMO_NONE) |-> (res_q.phase == PH_IDLE))
    else $error("timeout result must leave the session idle");

  a_foreign_no_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.foreign_sender |-> !res_q.deliver && (res_q.note == NOTE_NORMAL))
    else $error("dropped datagram delivered or noted");

  a_req_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.send_request != REQ_NONE) |->
      ((res_q.send_request == REQ_START) && (res_q.phase == PH_WAIT_START)) ||
      ((res_q.send_request == REQ_STOP) && (res_q.phase == PH_WAIT_STOP)))
    else $error("request sent without entering its ack wait");

  a_result_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (res_q.phase == phase_q))
    else $error("reported phase differs from session phase");

endmodule

// File: sv/ucs_cfg_regs.sv
// ucs_cfg_regs: configuration register bank written through a plain write port.
// Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_cfg_regs (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [ucs_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [ucs_pkg::CfgDataW-1:0] wdata_i,
  output ucs_pkg::cfg_t           cfg_o
);
  import ucs_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peer_address     <= RstPeerAddr;
      cfg_q.peer_port        <= RstPeerPort;
      cfg_q.ack_timeout      <= RstAckTimeout;
      cfg_q.expected_packets <= RstExpected;
    end else if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_PEER_ADDR: cfg_q.peer_address     <= wdata_i[AddrW-1:0];
        CFG_PEER_PORT: cfg_q.peer_port        <= wdata_i[PortW-1:0];
        CFG_ACK_TMO:   cfg_q.ack_timeout      <= wdata_i[TicksW-1:0];
        CFG_EXPECTED:  cfg_q.expected_packets <= wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
